// ----- rtl/core/tti_pkg.sv -----
// ----------------------------------------------------------------------------
// tti_pkg: shared types and constants of the trilinear table interpolator
// Table geometry, fixed-point widths and the queue entry layout.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int SLABS     = 20;
  localparam int GRID      = 32;
  localparam int PRESSURES = 4;
  localparam int LAST_SLAB = 17;

  localparam int SLAB_W = 5;
  localparam int GRID_W = 5;
  localparam int PRES_W = 2;

  // 20 slabs split evenly into parity banks, so a bank of slabs
  // holds either even or odd slab numbers (10 each)
  localparam int SLAB_HALF   = SLABS / 2;
  localparam int SLAB_HALF_W = 4;
  localparam int GRID_HALF_W = GRID_W - 1;
  // bank address: {desorb, pressure, slab/2, row/2, col/2}
  localparam int BANK_AW     = 1 + PRES_W + SLAB_HALF_W + 2 * GRID_HALF_W;
  localparam int BANK_DEPTH  = 2 * PRESSURES * 16 * (GRID / 2) * (GRID / 2);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [15:0] RECIP_RESET = 16'd10240;
  localparam logic [15:0] START_Q11   = 16'd4096;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [47:0] AMOUNT_MAX  = '1;

  // one item after classification in the front part
  typedef struct packed {
    logic                  is_query;
    logic                  wr_ok;
    logic                  desorb;
    logic [PRES_W-1:0]     pres;
    logic [SLAB_W-1:0]     s0;
    logic [GRID_W-1:0]     r0;
    logic [GRID_W-1:0]     c0;
    logic [16:0]           wa;
    logic [16:0]           wb;
    logic [16:0]           wc;
    logic                  flag;
    logic [31:0]           value;
    logic [15:0]           sa;
    logic [15:0]           sb;
    logic [15:0]           sc;
  } item_t;

endpackage

// ----- rtl/core/trilinear_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// trilinear_table_interpolator: table lookup with trilinear blend
// Top level joining the front part, the item queue and the back part.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items; s_axis_tuser holds opcode and desorb. opcode 0
//   writes entry_value into the table at desorb/pressure_sel/slab/row/col
//   and gives no result; opcode 1 is a query on size_a/size_b/size_c that
//   gives one m_axis transaction, amount in tdata, out_of_range in tuser.
//   cfg channel writes grid_step_recip (Q6.10), reset value 10.0; write it
//   only while no item is in flight.
//   Throughput: one item per cycle unless m_axis stalls; the eight corners
//   come from eight parity banks of the table, each read once per query.
//   Between the s_axis transaction and m_axis_tvalid lie 2 front stages,
//   the queue, 7 back stages and the output register.
//   A table write reaches the banks after the front stages, so a query
//   accepted after the write sees it.
//   Reset clears control state only; table contents are undefined until
//   written. When m_axis stalls the back part holds, the queue fills, and
//   then s_axis_tready drops.
module trilinear_table_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode, desorb
  input  logic [1:0]  s_axis_tuser,
  // pressure_sel, slab, row, col, entry_value, size_a, size_b, size_c
  input  logic [103:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // amount
  output logic [47:0] m_axis_tdata,
  // out_of_range
  output logic        m_axis_tuser
);

  logic [15:0] recip;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) recip <= tti_pkg::RECIP_RESET;
    else if (cfg_valid) recip <= cfg_data;
  end

  logic           f_valid;
  logic           f_ready;
  tti_pkg::item_t f_item;
  logic           q_valid;
  logic           q_ready;
  tti_pkg::item_t q_item;

  tti_front u_front (
    .clk(clk), .rst(rst), .recip(recip),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .opcode(s_axis_tuser[0]), .desorb(s_axis_tuser[1]),
    .pressure_sel(s_axis_tdata[1:0]), .slab(s_axis_tdata[6:2]),
    .row(s_axis_tdata[11:7]), .col(s_axis_tdata[16:12]),
    .entry_value(s_axis_tdata[48:17]), .size_a(s_axis_tdata[64:49]),
    .size_b(s_axis_tdata[80:65]), .size_c(s_axis_tdata[96:81]),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  tti_fifo u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  tti_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .amount(m_axis_tdata), .out_of_range(m_axis_tuser)
  );

endmodule

// ----- rtl/core/tti_front.sv -----
// ----------------------------------------------------------------------------
// tti_front: input stage of the trilinear table interpolator
// Accepts items, locates slab/row/col cells and weights, registers result.
// ----------------------------------------------------------------------------
module tti_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           recip,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic                  desorb,
  input  logic [1:0]            pressure_sel,
  input  logic [4:0]            slab,
  input  logic [4:0]            row,
  input  logic [4:0]            col,
  input  logic [31:0]           entry_value,
  input  logic [15:0]           size_a,
  input  logic [15:0]           size_b,
  input  logic [15:0]           size_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tti_pkg::item_t        out_item
);

  // stage 1: row and col axis products (size - 2.0) * recip
  logic        s1_valid;
  logic        s1_ready;
  logic [31:0] s1_pb;
  logic [31:0] s1_pc;
  logic        s1_flag;
  tti_pkg::item_t s1_item;

  logic [15:0] db;
  logic [15:0] dc;
  logic        lo_flag;
  logic        s1_load;

  assign db      = (size_b < tti_pkg::START_Q11) ? 16'd0 : size_b - tti_pkg::START_Q11;
  assign dc      = (size_c < tti_pkg::START_Q11) ? 16'd0 : size_c - tti_pkg::START_Q11;
  assign lo_flag = (size_b < tti_pkg::START_Q11) || (size_c < tti_pkg::START_Q11);
  assign in_ready = !s1_valid || s1_ready;
  assign s1_load  = in_valid && in_ready;

  // slab locate: clamp size_a, split slab index and weight
  logic [15:0]               pa;
  logic                      a_flag;
  logic [tti_pkg::SLAB_W-1:0] s0a;
  logic [16:0]               wa;
  always_comb begin
    a_flag = size_a > 16'((tti_pkg::LAST_SLAB + 1) << 11);
    pa     = a_flag ? 16'((tti_pkg::LAST_SLAB + 1) << 11) : size_a;
    if (32'(pa[15:11]) > 32'(tti_pkg::LAST_SLAB)) begin
      s0a = tti_pkg::SLAB_W'(tti_pkg::LAST_SLAB);
      wa  = tti_pkg::ONE_Q16;
    end else begin
      s0a = pa[15:11];
      wa  = {1'b0, pa[10:0], 5'd0};
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_load) begin
      s1_pb            <= db * recip;
      s1_pc            <= dc * recip;
      s1_flag          <= lo_flag || a_flag;
      s1_item.is_query <= opcode == tti_pkg::OP_QUERY;
      s1_item.wr_ok    <= 32'(slab) < 32'(tti_pkg::SLABS);
      s1_item.desorb   <= desorb;
      s1_item.pres     <= pressure_sel;
      s1_item.s0       <= (opcode == tti_pkg::OP_QUERY) ? s0a : slab;
      s1_item.r0       <= row;
      s1_item.c0       <= col;
      s1_item.wa       <= wa;
      s1_item.wb       <= '0;
      s1_item.wc       <= '0;
      s1_item.flag     <= 1'b0;
      s1_item.value    <= entry_value;
      s1_item.sa       <= size_a;
      s1_item.sb       <= size_b;
      s1_item.sc       <= size_c;
    end
  end

  // stage 2: saturate and split row and col positions
  localparam logic [31:0] MAXPOS = 32'((tti_pkg::GRID - 1) << 21);
  logic [31:0]               pb;
  logic [31:0]               pc;
  logic                      fb;
  logic                      fc;
  logic [tti_pkg::GRID_W-1:0] r0q;
  logic [tti_pkg::GRID_W-1:0] c0q;
  logic [16:0]               wbq;
  logic [16:0]               wcq;
  tti_pkg::item_t            s2_item;
  always_comb begin
    fb = s1_pb > MAXPOS;
    fc = s1_pc > MAXPOS;
    pb = fb ? MAXPOS : s1_pb;
    pc = fc ? MAXPOS : s1_pc;
    if (32'(pb[31:21]) > 32'(tti_pkg::GRID - 2)) begin
      r0q = tti_pkg::GRID_W'(tti_pkg::GRID - 2);
      wbq = tti_pkg::ONE_Q16;
    end else begin
      r0q = pb[21 +: tti_pkg::GRID_W];
      wbq = {1'b0, pb[20:5]};
    end
    if (32'(pc[31:21]) > 32'(tti_pkg::GRID - 2)) begin
      c0q = tti_pkg::GRID_W'(tti_pkg::GRID - 2);
      wcq = tti_pkg::ONE_Q16;
    end else begin
      c0q = pc[21 +: tti_pkg::GRID_W];
      wcq = {1'b0, pc[20:5]};
    end
  end

  // queries take the located row and col, writes pass as they are
  always_comb begin
    s2_item = s1_item;
    if (s1_item.is_query) begin
      s2_item.r0   = r0q;
      s2_item.c0   = c0q;
      s2_item.wb   = wbq;
      s2_item.wc   = wcq;
      s2_item.flag = s1_flag || fb || fc;
    end
  end

  assign s1_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && s1_ready) begin
      out_item <= s2_item;
    end
  end

  // assertions
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_query |-> out_item.wb <= tti_pkg::ONE_Q16)
    else $error("row weight above one");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_query |-> 32'(out_item.s0) <= 32'(tti_pkg::LAST_SLAB))
    else $error("base slab beyond last");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid)
    else $error("stage one item dropped");

endmodule

// ----- rtl/core/tti_fifo.sv -----
// ----------------------------------------------------------------------------
// tti_fifo: short queue between front and back parts
// Four-entry register queue of classified items.
// ----------------------------------------------------------------------------
module tti_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tti_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output tti_pkg::item_t out_item
);

  tti_pkg::item_t mem [4];
  logic [1:0]     wptr;
  logic [1:0]     rptr;
  logic [2:0]     count;
  logic           push;
  logic           pop;

  assign in_ready  = count != 3'd4;
  assign out_valid = count != 3'd0;
  assign out_item  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_item;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    count == 3'd4 |-> !in_ready)
    else $error("full queue accepts");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 3'd1)
    else $error("queue count mismatch");

endmodule

// ----- rtl/core/tti_back.sv -----
// ----------------------------------------------------------------------------
// tti_back: table and arithmetic part of the trilinear table interpolator
// Eight parity banks feed col, row and slab blends, then volume scaling.
// ----------------------------------------------------------------------------
module tti_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tti_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [47:0]    amount,
  output logic           out_of_range
);

  localparam int NST = 7;

  // pipeline advances as a whole; output register drains it
  logic           adv;
  logic [NST-1:0] v;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // bank addressing for one corner
  function automatic logic [tti_pkg::BANK_AW-1:0] bank_addr(
    input logic d, input logic [1:0] p, input logic [4:0] s,
    input logic [4:0] r, input logic [4:0] c);
    bank_addr = {d, p, s[4:1], r[4:1], c[4:1]};
  endfunction

  logic [tti_pkg::SLAB_W-1:0] s1;
  logic [tti_pkg::GRID_W-1:0] r1;
  logic [tti_pkg::GRID_W-1:0] c1;
  assign s1 = in_item.s0 + 5'd1;
  assign r1 = in_item.r0 + 5'd1;
  assign c1 = in_item.c0 + 5'd1;

  logic do_query;
  logic do_write;
  assign do_query = adv && in_valid && in_item.is_query;
  assign do_write = adv && in_valid && !in_item.is_query && in_item.wr_ok;

  // eight banks, bank index {slab parity, row parity, col parity}
  logic [31:0] rd [8];
  genvar g;
  generate
    for (g = 0; g < 8; g++) begin : g_bank
      localparam logic PS = 1'((g >> 2) & 1);
      localparam logic PR = 1'((g >> 1) & 1);
      localparam logic PC = 1'(g & 1);
      logic [31:0] mem [tti_pkg::BANK_DEPTH];
      logic [4:0] ss;
      logic [4:0] rr;
      logic [4:0] cc;
      logic       wsel;
      // corner of this bank: base or next index by parity
      assign ss = (in_item.s0[0] == PS) ? in_item.s0 : s1;
      assign rr = (in_item.r0[0] == PR) ? in_item.r0 : r1;
      assign cc = (in_item.c0[0] == PC) ? in_item.c0 : c1;
      assign wsel = in_item.s0[0] == PS && in_item.r0[0] == PR &&
                    in_item.c0[0] == PC;
      always_ff @(posedge clk) begin
        if (do_write && wsel)
          mem[bank_addr(in_item.desorb, in_item.pres, in_item.s0,
                        in_item.r0, in_item.c0)] <= in_item.value;
        if (do_query)
          rd[g] <= mem[bank_addr(in_item.desorb, in_item.pres, ss, rr, cc)];
      end
    end
  endgenerate

  // sideband carried with the reads
  logic        par_s;
  logic        par_r;
  logic        par_c;
  logic [16:0] wa1, wb1, wc1;
  logic        flag [NST];
  logic [15:0] sa1, sb1, sc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], in_valid && in_item.is_query};
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      par_s   <= in_item.s0[0];
      par_r   <= in_item.r0[0];
      par_c   <= in_item.c0[0];
      wa1     <= in_item.wa;
      wb1     <= in_item.wb;
      wc1     <= in_item.wc;
      flag[0] <= in_item.flag;
      sa1     <= in_item.sa;
      sb1     <= in_item.sb;
      sc1     <= in_item.sc;
    end
  end

  // blend (v0*(1-w) + v1*w + 2^15) >> 16
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [16:0] w);
    logic [49:0] t;
    t = 50'(a) * 50'(tti_pkg::ONE_Q16 - w) + 50'(b) * 50'(w) + 50'd32768;
    blend = t[47:16];
  endfunction

  // corner for (slab k, row j, col i) from bank by parity
  function automatic logic [2:0] bidx(input logic ps, input logic pr, input logic pc,
                                      input logic k, input logic j, input logic i);
    bidx = {ps ^ k, pr ^ j, pc ^ i};
  endfunction

  // stage 2: col blends, volume first product
  logic [31:0] cb [4];
  logic [16:0] wa2, wb2;
  logic [31:0] vab;
  logic [15:0] sc2;
  always_ff @(posedge clk) begin
    if (adv && v[0]) begin
      for (int k = 0; k < 2; k++)
        for (int j = 0; j < 2; j++)
          cb[2*k+j] <= blend(rd[bidx(par_s, par_r, par_c, k[0], j[0], 1'b0)],
                             rd[bidx(par_s, par_r, par_c, k[0], j[0], 1'b1)], wc1);
      wa2     <= wa1;
      wb2     <= wb1;
      vab     <= sa1 * sb1;
      sc2     <= sc1;
      flag[1] <= flag[0];
    end
  end

  // stage 3: row blends, volume second product
  logic [31:0] rb [2];
  logic [16:0] wa3;
  logic [47:0] vabc;
  always_ff @(posedge clk) begin
    if (adv && v[1]) begin
      rb[0]   <= blend(cb[0], cb[1], wb2);
      rb[1]   <= blend(cb[2], cb[3], wb2);
      wa3     <= wa2;
      vabc    <= vab * sc2;
      flag[2] <= flag[1];
    end
  end

  // stage 4: slab blend, volume rounding
  logic [31:0] conc;
  logic [32:0] vol;
  logic [48:0] vr;
  assign vr = 49'(vabc) + 49'd32768;
  always_ff @(posedge clk) begin
    if (adv && v[2]) begin
      conc    <= blend(rb[0], rb[1], wa3);
      vol     <= vr[48:16];
      flag[3] <= flag[2];
    end
  end

  // stages 5 and 6: 32x33 product in two partial products
  logic [48:0] pp_lo;
  logic [48:0] pp_hi;
  logic [64:0] prod;
  always_ff @(posedge clk) begin
    if (adv && v[3]) begin
      pp_lo   <= 49'(conc) * 49'(vol[16:0]);
      pp_hi   <= 49'(conc) * 49'(vol[32:17]);
      flag[4] <= flag[3];
    end
    if (adv && v[4]) begin
      prod    <= 65'(pp_lo) + (65'(pp_hi) << 17);
      flag[5] <= flag[4];
    end
  end

  // stage 7: round; saturation follows in the output register
  logic [48:0] amt;
  assign amt = 49'(prod[64:17]) + 49'(prod[16]);
  always_ff @(posedge clk) begin
    if (adv && v[5]) begin
      flag[6] <= flag[5];
    end
  end
  logic [48:0] amt_r;
  always_ff @(posedge clk) begin
    if (adv && v[5]) amt_r <= amt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[6];
    end
    if (adv && v[6]) begin
      amount       <= amt_r[48] ? tti_pkg::AMOUNT_MAX : amt_r[47:0];
      out_of_range <= flag[6];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v))
    else $error("pipeline moved while stalled");
  assert property (@(posedge clk) disable iff (rst)
    do_query |-> !do_write)
    else $error("read and write together");

endmodule
